// ===== hdl/tbq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbq_pkg
// Shared types and constants of the three-axis biquad low-pass core:
// coefficient set, lane control group and register indexes.
// ----------------------------------------------------------------------------
package tbq_pkg;

   localparam int COEF_W       = 32;
   localparam int FRAC_SHIFT   = 30;
   localparam int CSR_INDEX_W  = 2;

   // half of one output lsb at the Q2.30 product scale
   localparam logic [FRAC_SHIFT-1:0] ROUND_HALF = FRAC_SHIFT'(1) << (FRAC_SHIFT - 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FF_GAIN     = 2'd0,
      CSR_FB_COEF_ONE = 2'd1,
      CSR_FB_COEF_TWO = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] ff_gain;
      logic signed [COEF_W-1:0] fb_coef_one;
      logic signed [COEF_W-1:0] fb_coef_two;
   } coef_set_type;

   typedef struct packed {
      logic accept;   // item enters the feedforward stage
      logic fire;     // item leaves the feedforward stage into the output register
   } lane_ctrl_type;

endpackage

// ===== hdl/tbq_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbq_lane
// One axis of the filter: feedforward product stage, feedback stage with
// rounding and saturation, and the input and output histories.
// ----------------------------------------------------------------------------
module tbq_lane #(
   parameter int SAMPLE_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tbq_pkg::lane_ctrl_type         ctrl,
   input  tbq_pkg::coef_set_type          coef,
   input  logic signed [SAMPLE_BITS-1:0]  raw,
   output logic signed [SAMPLE_BITS-1:0]  smooth
);
   import tbq_pkg::*;

   localparam int SUM_W  = SAMPLE_BITS + 2;
   localparam int FF_W   = SUM_W + COEF_W;
   localparam int NEG_W  = SAMPLE_BITS + 1;
   localparam int FB_W   = NEG_W + COEF_W;
   localparam int ACC_W  = SAMPLE_BITS + 36;
   localparam int Q_W    = ACC_W - FRAC_SHIFT;

   localparam logic signed [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic signed [SAMPLE_BITS-1:0] x1_ff, x2_ff, y1_ff, y2_ff, smooth_ff;
   logic signed [SAMPLE_BITS-1:0] y_sat;
   logic signed [SUM_W-1:0]       x_sum;
   logic signed [FF_W-1:0]        ff_prod_ff, ff_prod_in;
   logic signed [FB_W-1:0]        fb2_prod_ff, fb2_prod_in, fb1_prod;
   logic signed [NEG_W-1:0]       neg_y1, neg_fb2_src;
   logic signed [SAMPLE_BITS-1:0] fb2_src;
   logic signed [ACC_W-1:0]       acc, acc_rounded;
   logic signed [Q_W-1:0]         q;
   logic                          q_fits;

   // x0 + 2*x1 + x2
   assign x_sum = {{2{raw[SAMPLE_BITS-1]}}, raw}
                + {x1_ff[SAMPLE_BITS-1], x1_ff, 1'b0}
                + {{2{x2_ff[SAMPLE_BITS-1]}}, x2_ff};

   assign ff_prod_in = x_sum * coef.ff_gain;

   // the y2 term of the next item is the current y1 once this item fires
   assign fb2_src     = ctrl.fire ? y1_ff : y2_ff;
   assign neg_fb2_src = -{fb2_src[SAMPLE_BITS-1], fb2_src};
   assign fb2_prod_in = neg_fb2_src * coef.fb_coef_two;

   assign neg_y1   = -{y1_ff[SAMPLE_BITS-1], y1_ff};
   assign fb1_prod = neg_y1 * coef.fb_coef_one;

   assign acc = {{(ACC_W-FF_W){ff_prod_ff[FF_W-1]}}, ff_prod_ff}
              + {{(ACC_W-FB_W){fb1_prod[FB_W-1]}}, fb1_prod}
              + {{(ACC_W-FB_W){fb2_prod_ff[FB_W-1]}}, fb2_prod_ff};

   // ties go toward plus infinity
   assign acc_rounded = acc + ACC_W'(ROUND_HALF);
   assign q           = acc_rounded[ACC_W-1:FRAC_SHIFT];
   assign q_fits      = (&q[Q_W-1:SAMPLE_BITS-1]) || !(|q[Q_W-1:SAMPLE_BITS-1]);

   always_comb begin
      if (q_fits) begin
         y_sat = q[SAMPLE_BITS-1:0];
      end else if (q[Q_W-1]) begin
         y_sat = SAT_MIN;
      end else begin
         y_sat = SAT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff       <= '0;
         x2_ff       <= '0;
         y1_ff       <= '0;
         y2_ff       <= '0;
         fb2_prod_ff <= '0;
      end else begin
         fb2_prod_ff <= fb2_prod_in;
         if (ctrl.accept) begin
            x1_ff <= raw;
            x2_ff <= x1_ff;
         end
         if (ctrl.fire) begin
            y1_ff <= y_sat;
            y2_ff <= y1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         ff_prod_ff <= ff_prod_in;
      end
      if (ctrl.fire) begin
         smooth_ff <= y_sat;
      end
   end

   assign smooth = smooth_ff;

endmodule

// ===== hdl/three_axis_biquad_lowpass_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_axis_biquad_lowpass_core
// Path: from item acceptance to rsp_tvalid through the feedforward product
//   register, then feedback multiply-add, round and saturate into rsp_tdata.
// Throughput: 1 item per cycle unless rsp_tready stalls; the y1 feedback multiply-add per lane is the loop.
// Reset: synchronous; clears histories, coefficients and both valid stages.
// ----------------------------------------------------------------------------
module three_axis_biquad_lowpass_core #(
   parameter int AXES        = 3,
   parameter int SAMPLE_BITS = 32
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           req_tvalid,
   output logic                                           req_tready,
   // raw_x, raw_y, raw_z, ... from bit 0 up, SAMPLE_BITS each, zero padded
   input  logic [((AXES*SAMPLE_BITS+7)/8)*8-1:0]          req_tdata,
   output logic                                           rsp_tvalid,
   input  logic                                           rsp_tready,
   // smooth_x, smooth_y, smooth_z, ... from bit 0 up, SAMPLE_BITS each, zero padded
   output logic [((AXES*SAMPLE_BITS+7)/8)*8-1:0]          rsp_tdata,
   input  logic                                           csr_valid,
   output logic                                           csr_ready,
   input  logic [tbq_pkg::CSR_INDEX_W-1:0]                csr_index,
   input  logic [tbq_pkg::COEF_W-1:0]                     csr_data
);
   import tbq_pkg::*;

   coef_set_type  coef_ff, coef_in;
   lane_ctrl_type lane_ctrl;
   logic          stage_valid_ff, stage_valid_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          advance, accept, csr_accept;
   logic signed [SAMPLE_BITS-1:0] smooth [AXES];

   // ---------------- configuration
   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;

   always_comb begin
      coef_in = coef_ff;
      if (csr_accept) begin
         unique case (csr_index_type'(csr_index))
            CSR_FF_GAIN:     coef_in.ff_gain     = csr_data;
            CSR_FB_COEF_ONE: coef_in.fb_coef_one = csr_data;
            CSR_FB_COEF_TWO: coef_in.fb_coef_two = csr_data;
            default:         coef_in = coef_ff;
         endcase
      end
   end

   // ---------------- pipeline control
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !stage_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   assign lane_ctrl.accept = accept;
   assign lane_ctrl.fire   = stage_valid_ff && advance;

   assign stage_valid_in = accept || (stage_valid_ff && !advance);
   assign rsp_valid_in   = advance ? stage_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff        <= '0;
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         coef_ff        <= coef_in;
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // ---------------- lanes
   for (genvar a = 0; a < AXES; a++) begin : g_lane
      tbq_lane #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (lane_ctrl),
         .coef   (coef_ff),
         .raw    (req_tdata[a*SAMPLE_BITS +: SAMPLE_BITS]),
         .smooth (smooth[a])
      );
   end

   // merge lane results into one item
   always_comb begin
      rsp_tdata = '0;
      for (int a = 0; a < AXES; a++) begin
         rsp_tdata[a*SAMPLE_BITS +: SAMPLE_BITS] = smooth[a];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   // ---------------- assertions
   a_fire_gives_result : assert property (@(posedge clock) disable iff (reset)
      lane_ctrl.fire |=> rsp_valid_ff)
      else $error("item left the feedforward stage but no result followed");

   a_accept_held : assert property (@(posedge clock) disable iff (reset)
      accept && !lane_ctrl.fire |=> stage_valid_ff)
      else $error("accepted item lost in the feedforward stage");

   a_no_invented_result : assert property (@(posedge clock) disable iff (reset)
      !stage_valid_ff && !rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result appeared with no item in flight");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the three-axis biquad low-pass core against a cycle-free predictor
// of the filter. Directed items cover reset coefficients, saturation, rounding
// ties and a step response. Random streams then run under several coefficient
// sets, with random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb;

   import tbq_pkg::*;

   localparam int AXES          = 3;
   localparam int SAMPLE_BITS   = 32;
   localparam int DATA_W        = ((AXES * SAMPLE_BITS + 7) / 8) * 8;
   localparam int ACC_W         = 80;
   localparam int MAX_WAIT      = 15;
   localparam int DRAIN_CYCLES  = 4;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS   = 315;
   localparam int MAX_REPORTS   = 50;

   // index beyond the register file, writes to it must be dropped
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   localparam logic [31:0] S32_MAX  = 32'h7FFF_FFFF;
   localparam logic [31:0] S32_MIN  = 32'h8000_0000;
   localparam logic [31:0] NEG_ONE  = 32'hFFFF_FFFF;
   localparam logic [31:0] ONE_Q16  = 32'h0001_0000;
   localparam logic [31:0] HALF_Q30 = 32'h2000_0000;

   // damping 0.9 low-pass sets, already divided by a0
   localparam logic [31:0] BW_SLOW_G  = 32'sd20557000;
   localparam logic [31:0] BW_SLOW_C1 = -32'sd1597966000;
   localparam logic [31:0] BW_SLOW_C2 = 32'sd606460000;
   localparam logic [31:0] BW_FAST_G  = 32'sd199877000;
   localparam logic [31:0] BW_FAST_C1 = -32'sd357556000;
   localparam logic [31:0] BW_FAST_C2 = 32'sd83344000;

   localparam logic signed [ACC_W-1:0] SAT_HIGH = (80'sd1 <<< (SAMPLE_BITS - 1)) - 80'sd1;
   localparam logic signed [ACC_W-1:0] SAT_LOW  = -(80'sd1 <<< (SAMPLE_BITS - 1));

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [DATA_W-1:0]        req_tdata  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [DATA_W-1:0]        rsp_tdata;
   logic                     csr_valid  = 1'b0;
   logic                     csr_ready;
   logic [CSR_INDEX_W-1:0]   csr_index  = '0;
   logic [COEF_W-1:0]        csr_data   = '0;

   // filter state as the core should hold it
   logic signed [COEF_W-1:0]      gain_q   = '0;
   logic signed [COEF_W-1:0]      fb_one_q = '0;
   logic signed [COEF_W-1:0]      fb_two_q = '0;
   logic signed [SAMPLE_BITS-1:0] hist_x1 [AXES] = '{default: '0};
   logic signed [SAMPLE_BITS-1:0] hist_x2 [AXES] = '{default: '0};
   logic signed [SAMPLE_BITS-1:0] hist_y1 [AXES] = '{default: '0};
   logic signed [SAMPLE_BITS-1:0] hist_y2 [AXES] = '{default: '0};

   logic [DATA_W-1:0] expected_smooth [$];

   int cycle_count   = 0;
   int error_count   = 0;
   int results_seen  = 0;
   int req_max_gap   = MAX_WAIT;
   int rsp_max_stall = MAX_WAIT;
   int stall_left    = 0;

   three_axis_biquad_lowpass_core #(
      .AXES        (AXES),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic int pick_wait(int max_wait);
      return (max_wait == 0) ? 0 : int'($urandom_range(0, max_wait));
   endfunction

   function automatic logic [31:0] rand_signed(int span);
      return 32'($urandom_range(0, 2 * span) - span);
   endfunction

   function automatic logic [31:0] pick_extreme();
      case ($urandom_range(0, 3))
         0: return S32_MAX;
         1: return S32_MIN;
         2: return '0;
         default: return NEG_ONE;
      endcase
   endfunction

   // mostly small or slowly moving samples, now and then anything at all
   function automatic logic [31:0] pick_sample(logic [31:0] prev);
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return pick_extreme();
         2, 3, 4: return rand_signed(1 << 20);
         default: return prev + rand_signed(1 << 12);
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] axes3(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      return {z, y, x};
   endfunction

   // one filter step on all axes; advances the histories
   function automatic logic [DATA_W-1:0] filter_step(logic [DATA_W-1:0] raw);
      logic [DATA_W-1:0]             smooth;
      logic signed [ACC_W-1:0]       x0;
      logic signed [ACC_W-1:0]       acc;
      logic signed [ACC_W-1:0]       scaled;
      logic signed [SAMPLE_BITS-1:0] y;
      smooth = '0;
      for (int a = 0; a < AXES; a++) begin
         x0 = $signed(raw[a * SAMPLE_BITS +: SAMPLE_BITS]);
         acc = gain_q * (x0 + 2 * hist_x1[a] + hist_x2[a])
               - fb_one_q * hist_y1[a] - fb_two_q * hist_y2[a]
               + $signed({1'b0, ROUND_HALF});
         scaled = acc >>> FRAC_SHIFT;
         if (scaled > SAT_HIGH)
            y = SAT_HIGH[SAMPLE_BITS-1:0];
         else if (scaled < SAT_LOW)
            y = SAT_LOW[SAMPLE_BITS-1:0];
         else
            y = scaled[SAMPLE_BITS-1:0];
         hist_x2[a] = hist_x1[a];
         hist_x1[a] = x0[SAMPLE_BITS-1:0];
         hist_y2[a] = hist_y1[a];
         hist_y1[a] = y;
         smooth[a * SAMPLE_BITS +: SAMPLE_BITS] = y;
      end
      return smooth;
   endfunction

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_REPORTS)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   task automatic send_raw(input logic [DATA_W-1:0] raw);
      int gap;
      gap = pick_wait(req_max_gap);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= raw;
      do @(posedge clock); while (!req_tready);
      expected_smooth.push_back(filter_step(raw));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_smooth.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_FF_GAIN:     gain_q   = value;
         CSR_FB_COEF_ONE: fb_one_q = value;
         CSR_FB_COEF_TWO: fb_two_q = value;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_coefs(input logic [31:0] g, input logic [31:0] c1, input logic [31:0] c2);
      write_csr(CSR_FF_GAIN, g);
      write_csr(CSR_FB_COEF_ONE, c1);
      write_csr(CSR_FB_COEF_TWO, c2);
   endtask

   // result side: random stall after each accepted item
   always @(posedge clock) begin : rsp_pacing
      int draw;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         if (stall_left == 1)
            rsp_tready <= 1'b1;
      end else if (rsp_tvalid && rsp_tready) begin
         draw = pick_wait(rsp_max_stall);
         rsp_tready <= (draw == 0);
         stall_left <= draw;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_smooth
      logic [DATA_W-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_smooth.size() == 0) begin
            report_mismatch($sformatf("result %0d with nothing expected: %h",
                                      results_seen, rsp_tdata));
         end else begin
            want = expected_smooth.pop_front();
            for (int a = 0; a < AXES; a++) begin
               if (rsp_tdata[a * SAMPLE_BITS +: SAMPLE_BITS] !== want[a * SAMPLE_BITS +: SAMPLE_BITS])
                  report_mismatch($sformatf("result %0d axis %0d: expected %0d, got %0d",
                     results_seen, a, $signed(want[a * SAMPLE_BITS +: SAMPLE_BITS]),
                     $signed(rsp_tdata[a * SAMPLE_BITS +: SAMPLE_BITS])));
            end
         end
      end
   end

   // coefficients still zero after reset, so every result is zero
   task automatic test_reset_defaults();
      send_raw(axes3(S32_MAX, S32_MIN, '0));
      send_raw(axes3(S32_MIN, NEG_ONE, S32_MAX));
      send_raw(axes3('0, S32_MAX, NEG_ONE));
      send_raw(axes3(NEG_ONE, '0, S32_MIN));
   endtask

   task automatic test_saturation();
      wait_drained();
      write_coefs(S32_MAX, S32_MIN, S32_MAX);
      write_csr(CSR_UNUSED, '0);
      send_raw(axes3(S32_MAX, S32_MIN, 32'd1));
      send_raw(axes3(S32_MAX, S32_MIN, NEG_ONE));
      send_raw(axes3(S32_MIN, S32_MAX, '0));
      send_raw(axes3(S32_MIN, S32_MIN, S32_MAX));
      send_raw(axes3(S32_MAX, S32_MAX, S32_MIN));
      send_raw(axes3('0, '0, '0));
      wait_drained();
      write_coefs(S32_MIN, S32_MAX, S32_MIN);
      send_raw(axes3(S32_MAX, S32_MIN, NEG_ONE));
      send_raw(axes3(S32_MIN, 32'd1, S32_MAX));
   endtask

   // gain of one half: odd tap sums land exactly between two outputs
   task automatic test_rounding_ties();
      int tie_seq [9] = '{0, 0, 1, 0, 0, -1, 0, 0, -3};
      wait_drained();
      write_coefs(HALF_Q30, '0, '0);
      foreach (tie_seq[i])
         send_raw(axes3(32'(tie_seq[i]), 32'(-tie_seq[i]), 32'(3 * tie_seq[i])));
   endtask

   task automatic test_step_response();
      wait_drained();
      write_coefs(BW_SLOW_G, BW_SLOW_C1, BW_SLOW_C2);
      repeat (4) send_raw(axes3(ONE_Q16, -ONE_Q16, S32_MAX));
   endtask

   task automatic test_random_streams();
      logic [DATA_W-1:0]      raw;
      logic [SAMPLE_BITS-1:0] last_raw [AXES];
      raw = '0;
      foreach (last_raw[a])
         last_raw[a] = '0;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_drained();
         write_csr(CSR_UNUSED, $urandom);
         case (p)
            0: write_coefs(BW_SLOW_G, BW_SLOW_C1, BW_SLOW_C2);
            1: write_coefs($urandom, $urandom, $urandom);
            2: write_coefs(rand_signed(1 << 26), rand_signed(1 << 29), rand_signed(1 << 28));
            3: write_coefs(pick_extreme(), pick_extreme(), pick_extreme());
            4: write_coefs(BW_FAST_G, BW_FAST_C1, BW_FAST_C2);
            default: write_coefs($urandom, $urandom, $urandom);
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % 40 == 0) begin
               req_max_gap   = $urandom_range(0, 1) ? MAX_WAIT : 0;
               rsp_max_stall = $urandom_range(0, 1) ? MAX_WAIT : 0;
            end
            // hold the stream until everything in flight has come back
            if (p == 4 && i == PHASE_ITEMS / 2)
               wait_drained();
            for (int a = 0; a < AXES; a++) begin
               last_raw[a] = pick_sample(last_raw[a]);
               raw[a * SAMPLE_BITS +: SAMPLE_BITS] = last_raw[a];
            end
            send_raw(raw);
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_saturation();
      test_rounding_ties();
      test_step_response();
      test_random_streams();
      wait_drained();
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== three_axis_biquad_lowpass_core.f =====
hdl/tbq_pkg.sv
hdl/tbq_lane.sv
hdl/three_axis_biquad_lowpass_core.sv
bench/tb.sv
